// ----- rtl/core/bbt_pkg.sv -----
// Shared constants, codes and control types of the Bollinger band tracker.
package bbt_pkg;

  localparam int MAX_WINDOW = 256;

  localparam int SAMPLE_W   = 24;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int COEF_W     = 12;
  localparam int SUM_W      = SAMPLE_W + LEN_W;
  localparam int SQ_W       = 2 * SAMPLE_W + LEN_W;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int MSQ_W      = 2 * SAMPLE_W;
  localparam int LOWER_W    = SAMPLE_W + 1;
  localparam int DIV_W      = SQ_W + (SQ_W % 2);
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int SQRT_STEPS = SAMPLE_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam int LEN_RESET  = 20;
  localparam int COEF_RESET = 512;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COEF     = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_ADDX,
    ST_SUBO,
    ST_DIVQ_LD,
    ST_DIVQ,
    ST_DIVS_LD,
    ST_DIVS,
    ST_MSQ,
    ST_VAR,
    ST_SQRT,
    ST_BAND,
    ST_OUT
  } bbt_state_t;

  typedef enum logic [1:0] {
    MUL_SAMPLE,
    MUL_OLD,
    MUL_MEAN,
    MUL_BAND
  } bbt_mul_sel_t;

  typedef struct packed {
    logic         accept;
    logic         sum_upd;
    logic         sq_add;
    logic         sq_sub;
    logic         div_load_sq;
    logic         div_load_sum;
    logic         div_step;
    logic         msq_latch;
    logic         mean_latch;
    logic         var_load;
    logic         sqrt_step;
    logic         out_load;
    bbt_mul_sel_t mul_sel;
  } bbt_cmd_t;

  typedef struct packed {
    logic due;
    logic last_step;
    logic out_free;
  } bbt_stat_t;

endpackage

// ----- rtl/core/bbt_in_if.sv -----
// Input channel: one price sample per item.
interface bbt_in_if import bbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] price_sample;

  modport source (output valid, output price_sample, input ready);
  modport sink   (input valid, input price_sample, output ready);
endinterface

// ----- rtl/core/bbt_out_if.sv -----
// Result channel: mean, deviation and both bands per item.
interface bbt_out_if import bbt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_W-1:0]       moving_average;
  logic [SAMPLE_W-1:0]       std_deviation;
  logic [SAMPLE_W-1:0]       upper_band;
  logic signed [LOWER_W-1:0] lower_band;

  modport source (output valid, output moving_average, output std_deviation,
                  output upper_band, output lower_band, input ready);
  modport sink   (input valid, input moving_average, input std_deviation,
                  input upper_band, input lower_band, output ready);
endinterface

// ----- rtl/core/bbt_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface bbt_cfg_if import bbt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- rtl/core/bbt_ctrl.sv -----
// Sequencer for the tracker: steps the datapath through update, divides, root, bands and output.
module bbt_ctrl import bbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bbt_stat_t stat,
  output bbt_cmd_t  cmd
);

  bbt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_SQX;
      ST_SQX:     state_nxt = ST_ADDX;
      ST_ADDX:    state_nxt = ST_SUBO;
      ST_SUBO:    state_nxt = stat.due ? ST_DIVQ_LD : ST_IDLE;
      ST_DIVQ_LD: state_nxt = ST_DIVQ;
      ST_DIVQ:    if (stat.last_step) state_nxt = ST_DIVS_LD;
      ST_DIVS_LD: state_nxt = ST_DIVS;
      ST_DIVS:    if (stat.last_step) state_nxt = ST_MSQ;
      ST_MSQ:     state_nxt = ST_VAR;
      ST_VAR:     state_nxt = ST_SQRT;
      ST_SQRT:    if (stat.last_step) state_nxt = ST_BAND;
      ST_BAND:    state_nxt = ST_OUT;
      ST_OUT:     if (stat.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_BAND;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SQX: begin
        cmd.sum_upd = 1'b1;
        cmd.mul_sel = MUL_SAMPLE;
      end
      ST_ADDX: begin
        cmd.sq_add  = 1'b1;
        cmd.mul_sel = MUL_OLD;
      end
      ST_SUBO:    cmd.sq_sub = 1'b1;
      ST_DIVQ_LD: cmd.div_load_sq = 1'b1;
      ST_DIVQ:    cmd.div_step = 1'b1;
      ST_DIVS_LD: begin
        cmd.msq_latch    = 1'b1;
        cmd.div_load_sum = 1'b1;
      end
      ST_DIVS:    cmd.div_step = 1'b1;
      ST_MSQ: begin
        cmd.mean_latch = 1'b1;
        cmd.mul_sel    = MUL_MEAN;
      end
      ST_VAR:     cmd.var_load = 1'b1;
      ST_SQRT:    cmd.sqrt_step = 1'b1;
      ST_BAND:    cmd.mul_sel = MUL_BAND;
      ST_OUT:     cmd.out_load = stat.out_free;
      default:    cmd.mul_sel = MUL_BAND;
    endcase
  end

endmodule

// ----- rtl/core/bbt_datapath.sv -----
// Datapath: sample ring, running sums, shared multiplier, divider, square root, output stage.
module bbt_datapath import bbt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bbt_cmd_t                  cmd,
  output bbt_stat_t                 stat,
  input  logic [SAMPLE_W-1:0]       price_sample,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [SAMPLE_W-1:0]       moving_average,
  output logic [SAMPLE_W-1:0]       std_deviation,
  output logic [SAMPLE_W-1:0]       upper_band,
  output logic signed [LOWER_W-1:0] lower_band
);

  localparam int ROOT_W    = SAMPLE_W;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int STRY_W    = ROOT_W + 4;
  localparam int BAND_W    = PROD_W - 8;
  localparam int UPPER_MAX = 2 ** SAMPLE_W - 1;
  localparam int LOWER_OFS = 2 ** SAMPLE_W;

  // sample ring
  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] old_r;
  logic [SAMPLE_W-1:0] x_r;

  // window state
  logic [LEN_W-1:0]  len_r;
  logic [COEF_W-1:0] coef_r;
  logic [ADDR_W-1:0] wp_r;
  logic [LEN_W-1:0]  fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic              full_before_r;
  logic              due_r;

  logic [LEN_W-1:0]  wp_inc;
  logic [ADDR_W-1:0] wp_nxt;
  logic [LEN_W-1:0]  fill_nxt;
  logic [LEN_W-1:0]  len_clamped;

  // multiplier
  logic [SAMPLE_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]   prod_r;

  // divider and root
  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W:0]    div_t;
  logic              div_qb;
  logic [CNT_W-1:0]  cnt_r;
  logic [MSQ_W-1:0]  msq_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic [MSQ_W-1:0]  rad_r;
  logic [SREM_W-1:0] srem_r, srem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STRY_W-1:0] sq_try, sq_trial;

  // band arithmetic
  logic [BAND_W-1:0]   band_p;
  logic [BAND_W:0]     upper_sum;
  logic [BAND_W:0]     lower_lim;
  logic [BAND_W:0]     lower_diff;
  logic [SAMPLE_W-1:0] upper_val;
  logic [LOWER_W-1:0]  lower_val;

  // ring write and read of the slot being replaced (old contents come out)
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp_r] <= price_sample;
      old_r     <= mem[wp_r];
      x_r       <= price_sample;
    end
  end

  always_comb begin
    wp_inc   = LEN_W'(wp_r) + LEN_W'(1);
    wp_nxt   = (wp_inc >= len_r) ? '0 : wp_inc[ADDR_W-1:0];
    fill_nxt = (fill_r < len_r) ? fill_r + LEN_W'(1) : fill_r;
    if (cfg_data[LEN_W-1:0] < LEN_W'(2)) begin
      len_clamped = LEN_W'(2);
    end else if (cfg_data[LEN_W-1:0] > LEN_W'(MAX_WINDOW)) begin
      len_clamped = LEN_W'(MAX_WINDOW);
    end else begin
      len_clamped = cfg_data[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r         <= LEN_W'(LEN_RESET);
      coef_r        <= COEF_W'(COEF_RESET);
      wp_r          <= '0;
      fill_r        <= '0;
      sum_r         <= '0;
      sq_r          <= '0;
      full_before_r <= 1'b0;
      due_r         <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WINDOW_LENGTH) begin
        len_r  <= len_clamped;
        wp_r   <= '0;
        fill_r <= '0;
        sum_r  <= '0;
        sq_r   <= '0;
      end else if (cfg_index == CFG_BAND_COEF) begin
        coef_r <= cfg_data[COEF_W-1:0];
      end
    end else begin
      if (cmd.accept) begin
        wp_r          <= wp_nxt;
        fill_r        <= fill_nxt;
        full_before_r <= (fill_r >= len_r);
        due_r         <= (fill_nxt >= len_r);
      end
      if (cmd.sum_upd) begin
        sum_r <= sum_r + SUM_W'(x_r) - (full_before_r ? SUM_W'(old_r) : '0);
      end
      if (cmd.sq_add) begin
        sq_r <= sq_r + SQ_W'(prod_r);
      end
      if (cmd.sq_sub && full_before_r) begin
        sq_r <= sq_r - SQ_W'(prod_r);
      end
    end
  end

  // shared 24x24 multiplier, registered
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SAMPLE: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      MUL_OLD: begin
        mul_a = old_r;
        mul_b = old_r;
      end
      MUL_MEAN: begin
        mul_a = dq_r[SAMPLE_W-1:0];
        mul_b = dq_r[SAMPLE_W-1:0];
      end
      MUL_BAND: begin
        mul_a = SAMPLE_W'(coef_r);
        mul_b = root_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // restoring divide by the window length, two quotient bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    div_t   = '0;
    div_qb  = 1'b0;
    for (int i = 0; i < 2; i++) begin
      div_t = {rem_nxt, dq_nxt[DIV_W-1]};
      if (div_t >= {1'b0, len_r}) begin
        div_t  = div_t - {1'b0, len_r};
        div_qb = 1'b1;
      end else begin
        div_qb = 1'b0;
      end
      rem_nxt = div_t[LEN_W-1:0];
      dq_nxt  = {dq_nxt[DIV_W-2:0], div_qb};
    end
  end

  // digit-by-digit square root, one root bit per cycle
  always_comb begin
    sq_try   = {srem_r, rad_r[MSQ_W-1 -: 2]};
    sq_trial = {2'b00, root_r, 2'b01};
    if (sq_try >= sq_trial) begin
      srem_nxt = SREM_W'(sq_try - sq_trial);
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      srem_nxt = sq_try[SREM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_load_sq || cmd.div_load_sum) begin
      cnt_r <= CNT_W'(DIV_STEPS - 1);
    end else if (cmd.var_load) begin
      cnt_r <= CNT_W'(SQRT_STEPS - 1);
    end else if (cmd.div_step || cmd.sqrt_step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load_sq) begin
      dq_r  <= DIV_W'(sq_r);
      rem_r <= '0;
    end else if (cmd.div_load_sum) begin
      dq_r  <= DIV_W'(sum_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.msq_latch) begin
      msq_r <= dq_r[MSQ_W-1:0];
    end
    if (cmd.mean_latch) begin
      mean_r <= dq_r[SAMPLE_W-1:0];
    end
    // prod_r holds mean squared here; variance clamps at zero
    if (cmd.var_load) begin
      rad_r  <= (msq_r > prod_r) ? msq_r - prod_r : '0;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[MSQ_W-3:0], 2'b00};
      srem_r <= srem_nxt;
      root_r <= root_nxt;
    end
  end

  // bands: prod_r holds coefficient times deviation
  always_comb begin
    band_p     = prod_r[PROD_W-1:8];
    upper_sum  = (BAND_W + 1)'(mean_r) + {1'b0, band_p};
    lower_lim  = (BAND_W + 1)'(mean_r) + (BAND_W + 1)'(LOWER_OFS);
    lower_diff = (BAND_W + 1)'(mean_r) - {1'b0, band_p};
    upper_val  = (upper_sum > (BAND_W + 1)'(UPPER_MAX)) ? '1 : upper_sum[SAMPLE_W-1:0];
    lower_val  = ({1'b0, band_p} > lower_lim) ? {1'b1, {SAMPLE_W{1'b0}}}
                                              : lower_diff[LOWER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      moving_average <= mean_r;
      std_deviation  <= root_r;
      upper_band     <= upper_val;
      lower_band     <= $signed(lower_val);
    end
  end

  assign stat.due       = due_r;
  assign stat.last_step = (cnt_r == '0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ----- rtl/core/bollinger_band_tracker_core.sv -----
// Top level of the Bollinger band tracker: sequencer plus datapath.
//
// Usage:
//   in_ch  (sink)   : one unsigned Q16.8 price sample per item.
//   out_ch (source) : moving average, population deviation, upper band
//                     (saturated) and signed lower band, Q16.8.
//   cfg_ch (sink)   : register writes, always ready. Index 0 sets the
//                     window length (clamped to 2..256) and restarts the
//                     window; index 1 sets the Q4.8 band coefficient.
//                     Other indexes are ignored. Write only while idle.
// Sequence:
//   Items are taken one at a time. An item that only fills the window
//   passes the update states and returns to idle. Once the window holds
//   a full set, each item runs two 58-bit divides at two bits per cycle
//   and a 24-step square root, then its bands are formed and its result
//   is loaded; the next item is taken once that result is loaded.
// Reset clears the sums, fill count and write position and loads the
// register defaults (length 20, coefficient 2.0). A stalled result waits in
// the output register; the block keeps accepting and working on the next
// item and holds only before loading a newer result.
module bollinger_band_tracker_core import bbt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bbt_in_if.sink    in_ch,
  bbt_out_if.source out_ch,
  bbt_cfg_if.sink   cfg_ch
);

  bbt_cmd_t  cmd;
  bbt_stat_t stat;
  logic      in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  bbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .price_sample   (in_ch.price_sample),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.reg_index),
    .cfg_data       (cfg_ch.reg_data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .moving_average (out_ch.moving_average),
    .std_deviation  (out_ch.std_deviation),
    .upper_band     (out_ch.upper_band),
    .lower_band     (out_ch.lower_band)
  );

endmodule

// ----- rtl/core/bbt_port_monitor.sv -----
// Port-level assertions for the tracker, bound to the top level.
module bbt_port_monitor import bbt_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [SAMPLE_W-1:0]       moving_average,
  input logic [SAMPLE_W-1:0]       std_deviation,
  input logic [SAMPLE_W-1:0]       upper_band,
  input logic signed [LOWER_W-1:0] lower_band
);

  // one item at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item in flight");

  // a new result is only loaded while the input side is closed
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while block was idle");

  // bands bracket the mean
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((upper_band >= moving_average) &&
                   ($signed(lower_band) <= $signed({1'b0, moving_average}))))
    else $error("bands do not bracket the mean");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(moving_average) && $stable(std_deviation) &&
                                   $stable(upper_band) && $stable(lower_band)))
    else $error("result payload changed while stalled");

endmodule

bind bollinger_band_tracker_core bbt_port_monitor u_port_monitor (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .moving_average (out_ch.moving_average),
  .std_deviation  (out_ch.std_deviation),
  .upper_band     (out_ch.upper_band),
  .lower_band     (out_ch.lower_band)
);

// ----- bench/bollinger_band_checker.sv -----
`timescale 1ns / 100ps
// Checker for the Bollinger band tracker: tracks the window and compares each result.
module bollinger_band_checker import bbt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [SAMPLE_W-1:0]       in_price,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [SAMPLE_W-1:0]       out_mean,
  input  logic [SAMPLE_W-1:0]       out_dev,
  input  logic [SAMPLE_W-1:0]       out_upper,
  input  logic signed [LOWER_W-1:0] out_lower,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [SAMPLE_W-1:0]       mean;
    logic [SAMPLE_W-1:0]       dev;
    logic [SAMPLE_W-1:0]       upper;
    logic signed [LOWER_W-1:0] lower;
  } band_result_t;

  localparam logic [63:0] SAMPLE_MAX = 64'(2 ** SAMPLE_W - 1);
  localparam longint      LOWER_MIN  = -(longint'(1) << SAMPLE_W);

  logic [SAMPLE_W-1:0] price_ring [MAX_WINDOW];
  logic [63:0]         price_sum;
  logic [63:0]         square_sum;
  logic [LEN_W-1:0]    len_reg;
  logic [COEF_W-1:0]   coef_reg;
  int                  slot;
  int                  filled;
  int                  span;
  band_result_t        band_q [$];

  function automatic int clamp_len(logic [LEN_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return int'(v);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = SAMPLE_W - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic restart_window();
    price_sum  = '0;
    square_sum = '0;
    slot       = 0;
    filled     = 0;
    span       = clamp_len(len_reg);
  endtask

  // Push one sample into the window; once full, queue the bands it yields.
  task automatic advance_window(logic [SAMPLE_W-1:0] price);
    logic [63:0]  x;
    logic [63:0]  dropped;
    logic [63:0]  mean;
    logic [63:0]  mean_sq;
    logic [63:0]  sq_mean;
    logic [63:0]  variance;
    logic [63:0]  dev;
    logic [63:0]  offset;
    longint       upper;
    longint       lower;
    int           pos;
    band_result_t res;
    x   = 64'(price);
    pos = (slot >= span) ? 0 : slot;
    if (filled >= span) begin
      dropped    = 64'(price_ring[pos]);
      price_sum  = price_sum - dropped;
      square_sum = square_sum - dropped * dropped;
    end
    price_ring[pos] = price;
    price_sum       = price_sum + x;
    square_sum      = square_sum + x * x;
    pos++;
    slot = (pos >= span) ? 0 : pos;
    if (filled < span) filled++;
    if (filled < span) return;

    mean     = price_sum / 64'(span);
    mean_sq  = square_sum / 64'(span);
    sq_mean  = mean * mean;
    variance = (mean_sq > sq_mean) ? mean_sq - sq_mean : '0;
    dev      = floor_sqrt(variance);
    if (dev > SAMPLE_MAX) dev = SAMPLE_MAX;
    offset = (64'(coef_reg) * dev) >> 8;
    upper  = longint'(mean) + longint'(offset);
    if (upper > longint'(SAMPLE_MAX)) upper = longint'(SAMPLE_MAX);
    lower = longint'(mean) - longint'(offset);
    if (lower < LOWER_MIN) lower = LOWER_MIN;

    res.mean  = mean[SAMPLE_W-1:0];
    res.dev   = dev[SAMPLE_W-1:0];
    res.upper = upper[SAMPLE_W-1:0];
    res.lower = lower[LOWER_W-1:0];
    band_q.push_back(res);
  endtask

  task automatic check_field(string name, logic [LOWER_W-1:0] want, logic [LOWER_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    band_result_t res;
    if (!rst_n) begin
      len_reg  = LEN_W'(LEN_RESET);
      coef_reg = COEF_W'(COEF_RESET);
      restart_window();
      band_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: begin
            len_reg = cfg_data[LEN_W-1:0];
            restart_window();
          end
          CFG_BAND_COEF: coef_reg = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_window(in_price);
      if (out_valid && out_ready) begin
        if (band_q.size() == 0) begin
          $display("%0t: result with no item waiting, actual %h %h %h %h",
                   $time, out_mean, out_dev, out_upper, out_lower);
          fail_count++;
        end else begin
          res = band_q.pop_front();
          check_field("moving_average", LOWER_W'(res.mean), LOWER_W'(out_mean));
          check_field("std_deviation", LOWER_W'(res.dev), LOWER_W'(out_dev));
          check_field("upper_band", LOWER_W'(res.upper), LOWER_W'(out_upper));
          check_field("lower_band", res.lower, out_lower);
        end
      end
    end
    pending = band_q.size();
  end

endmodule

// ----- bench/bollinger_band_tracker_core_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the Bollinger band tracker: stimulus, idling and verdict.
module bollinger_band_tracker_core_test;
  import bbt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(15);
  localparam int                   DRAIN_CYCLES  = 120;
  localparam int                   PRICE_MAX     = 2 ** SAMPLE_W - 1;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  int   burst_left;
  int   gap_max;
  int   stall_max;
  int   ready_left;
  int   stall_left;
  int   walk_price;

  bbt_in_if  in_bus ();
  bbt_out_if out_bus ();
  bbt_cfg_if cfg_bus ();

  bollinger_band_tracker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  bollinger_band_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_price   (in_bus.price_sample),
    .cfg_valid  (cfg_bus.valid),
    .cfg_ready  (cfg_bus.ready),
    .cfg_index  (cfg_bus.reg_index),
    .cfg_data   (cfg_bus.reg_data),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_mean   (out_bus.moving_average),
    .out_dev    (out_bus.std_deviation),
    .out_upper  (out_bus.upper_band),
    .out_lower  (out_bus.lower_band),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: ready runs alternate with random stall stretches set by stall_max.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      ready_left = 0;
      stall_left = 0;
    end else if (ready_left > 0) begin
      out_bus.ready <= 1'b1;
      ready_left--;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      ready_left = $urandom_range(1, 40);
      stall_left = (stall_max > 0) ? $urandom_range(1, stall_max) : 0;
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] draw_price(int spread);
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      step       = $urandom_range(0, 2 * spread);
      walk_price = walk_price + step - spread;
      if (walk_price < 0) walk_price = 0;
      if (walk_price > PRICE_MAX) walk_price = PRICE_MAX;
      return SAMPLE_W'(walk_price);
    end
    if (pick < 75) return SAMPLE_W'($urandom);
    if (pick < 85) return $urandom_range(0, 1) ? SAMPLE_W'(PRICE_MAX) : '0;
    return SAMPLE_W'(walk_price);
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] price);
    int gap;
    in_bus.valid        <= 1'b1;
    in_bus.price_sample <= price;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.reg_data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all results, then give a trailing fill item time to finish.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(bit set_len, logic [CFG_DATA_W-1:0] len_val, bit set_coef,
                           logic [CFG_DATA_W-1:0] coef_val, int count, int spread,
                           int gaps, int stalls);
    settle();
    if (set_len) write_reg(CFG_WINDOW_LENGTH, len_val);
    if (set_coef) write_reg(CFG_BAND_COEF, coef_val);
    gap_max   = gaps;
    stall_max = stalls;
    walk_price = $urandom_range(0, PRICE_MAX);
    repeat (count) send_sample(draw_price(spread));
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.price_sample <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.reg_index   <= '0;
    cfg_bus.reg_data    <= '0;
    burst_left = 0;
    gap_max    = 0;
    stall_max  = 0;
    walk_price = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // window length zero acts as two; full coefficient saturates both bands
    settle();
    write_reg(CFG_WINDOW_LENGTH, '0);
    write_reg(CFG_BAND_COEF, CFG_DATA_W'(12'hFFF));
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_W'(PRICE_MAX));
    send_sample(SAMPLE_W'(PRICE_MAX));
    send_sample('0);
    send_sample('0);

    // zero coefficient: bands collapse onto the mean
    settle();
    write_reg(CFG_BAND_COEF, '0);
    send_sample(SAMPLE_W'(24'h123456));
    send_sample(SAMPLE_W'(24'hABCDEF));

    // length one acts as two; unknown indexes are ignored
    settle();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(1));
    write_reg(CFG_UNUSED_LO, CFG_DATA_W'(12'hFFF));
    write_reg(CFG_UNUSED_HI, '0);
    write_reg(CFG_BAND_COEF, CFG_DATA_W'(12'h100));
    send_sample(SAMPLE_W'(24'h800000));
    send_sample(SAMPLE_W'(24'h7FFFFF));
    send_sample(SAMPLE_W'(24'h000001));
    send_sample(SAMPLE_W'(24'hFFFFFE));

    // upper data bits above the length field are dropped: acts as three
    settle();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(12'hE03));
    send_sample(SAMPLE_W'(24'hAAAAAA));
    send_sample(SAMPLE_W'(24'h555555));
    send_sample(SAMPLE_W'(PRICE_MAX));
    send_sample('0);
    send_sample('0);

    run_phase(1, CFG_DATA_W'(LEN_RESET), 1, CFG_DATA_W'(COEF_RESET), 250, 256, 8, 0);
    run_phase(1, CFG_DATA_W'(MAX_WINDOW), 1, CFG_DATA_W'(12'hFFF), 450, 4096, 0, 0);
    // coefficient change only: window keeps its contents
    run_phase(0, '0, 1, CFG_DATA_W'(1), 150, 65536, 120, 150);
    run_phase(1, CFG_DATA_W'(12'h1FF), 1, CFG_DATA_W'(12'h800), 300, 1024, 8, 20);
    // partial fill, then restarted by the next length write
    run_phase(1, CFG_DATA_W'(50), 0, '0, 30, 512, 4, 3);
    run_phase(1, CFG_DATA_W'(2), 1, CFG_DATA_W'($urandom_range(0, 4095)), 250,
              1 << 20, 8, 150);
    repeat (3) begin
      run_phase(1, {CFG_DATA_W'($urandom_range(0, 7)) << LEN_W} |
                   CFG_DATA_W'($urandom_range(3, 64)),
                1, CFG_DATA_W'($urandom_range(0, 4095)), 200,
                $urandom_range(1, 1 << 16), $urandom_range(0, 100),
                $urandom_range(0, 100));
    end

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bbt_pkg.sv
rtl/core/bbt_in_if.sv
rtl/core/bbt_out_if.sv
rtl/core/bbt_cfg_if.sv
rtl/core/bbt_ctrl.sv
rtl/core/bbt_datapath.sv
rtl/core/bollinger_band_tracker_core.sv
rtl/core/bbt_port_monitor.sv
bench/bollinger_band_checker.sv
bench/bollinger_band_tracker_core_test.sv
